// File: hw/rtl/fsmf_pkg.sv
`timescale 1ns / 1ps

package fsmf_pkg;

  // Pattern register file: two 64-bit words hold up to sixteen bytes.
  localparam int PatRegBytes   = 16;
  localparam int PatWordBits   = 64;
  localparam int ByteBits      = 8;
  localparam int LenBits       = 5;
  localparam int OffsetBits    = 32;
  localparam int CfgIdxBits    = 2;

  // Defaults for the top-level parameters.
  localparam int MaxPatternDef   = 16;
  localparam int PositionBitsDef = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_PAT_LEN  = 2'd2;

  // Control handed from the top level to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/first_substring_match_finder_top.sv
`timescale 1ns / 1ps
// A result beat appears on m_axis in the cycle after the text byte that completes a
// match, or after the last byte of a text that had none. Throughput: one text byte per
// cycle unless a stalled result holds the input, set by the row of window cells that
// shifts and compares the whole window with the pattern in the cycle a byte is accepted.
// Reset: asynchronous, active low; clears the window, position, output valid and sets the
// pattern to all zero bytes with length one.

module first_substring_match_finder_top #(
  parameter int MaxPattern   = fsmf_pkg::MaxPatternDef,
  parameter int PositionBits = fsmf_pkg::PositionBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Text input stream.
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [7:0]                           s_axis_tdata_i,  // [7:0] text_byte
  input  logic                                 s_axis_tlast_i,  // last_byte
  // Result stream.
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [31:0]                          m_axis_tdata_o,  // [31:0] match_offset
  output logic [0:0]                           m_axis_tuser_o,  // [0] found
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fsmf_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [fsmf_pkg::PatWordBits-1:0]     cfg_data_i
);
  import fsmf_pkg::*;

  // Only the first min(MaxPattern, 16) window bytes can ever take part in a compare, so
  // the cell row is that long.
  localparam int CapLen = (MaxPattern < PatRegBytes) ? MaxPattern : PatRegBytes;

  // Configuration registers.
  logic [PatWordBits-1:0] pat_low_q, pat_high_q;
  logic [LenBits-1:0]     pat_len_q;
  logic [LenBits-1:0]     eff_len;

  // Search state.
  logic [PositionBits-1:0] pos_q, pos_d, pos_new;
  logic                    done_q, done_d;

  // Output register.
  logic                    out_valid_q;
  logic                    out_found_q;
  logic [OffsetBits-1:0]   out_offset_q;

  logic                    in_beat, active, last_beat;
  logic                    pos_ok, match, emit;
  logic [PositionBits-1:0] diff;
  logic [PositionBits+OffsetBits-1:0] diff_ext;
  cell_ctrl_t              cell_ctrl;

  logic [ByteBits-1:0]     cell_byte [CapLen];
  logic [CapLen-1:0]       cell_hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LenBits'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[LenBits-1:0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one; a length beyond the cell row is clipped to it.
  always_comb begin
    eff_len = pat_len_q;
    if (pat_len_q == '0) begin
      eff_len = LenBits'(1);
    end else if (pat_len_q > LenBits'(CapLen)) begin
      eff_len = LenBits'(CapLen);
    end
  end

  // The input side stalls only when a result waits and the sink is not taking it.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign last_beat = in_beat && s_axis_tlast_i;
  // Bytes after a reported match are dropped until the end of the text.
  assign active    = in_beat && !done_q;

  assign cell_ctrl.shift = active;
  assign cell_ctrl.clear = last_beat;

  // Window cells: cell 0 takes the new byte, every other cell takes its neighbor's.
  for (genvar j = 0; j < CapLen; j++) begin : g_cell
    logic [ByteBits-1:0] byte_in;
    if (j == 0) begin : g_head
      assign byte_in = s_axis_tdata_i;
    end else begin : g_link
      assign byte_in = cell_byte[j-1];
    end
    fsmf_cell #(
      .Position(j)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .byte_i   (byte_in),
      .pattern_i({pat_high_q, pat_low_q}),
      .len_i    (eff_len),
      .byte_o   (cell_byte[j]),
      .hit_o    (cell_hit[j])
    );
  end

  // The position counter saturates at its all-ones value.
  assign pos_new = (pos_q == '1) ? pos_q : pos_q + PositionBits'(1);
  assign pos_ok  = pos_new >= PositionBits'(eff_len);
  assign match   = active && pos_ok && (&cell_hit);
  assign emit    = match || (active && s_axis_tlast_i);

  assign diff     = pos_new - PositionBits'(eff_len);
  assign diff_ext = {{OffsetBits{1'b0}}, diff};

  always_comb begin
    pos_d  = pos_q;
    done_d = done_q;
    if (last_beat) begin
      pos_d  = '0;
      done_d = 1'b0;
    end else if (active) begin
      pos_d  = pos_new;
      done_d = match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      done_q <= done_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: only loaded together with a new result beat.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_found_q  <= match;
      out_offset_q <= match ? diff_ext[OffsetBits-1:0] : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_offset_q;
  assign m_axis_tuser_o  = out_found_q;

endmodule

// File: hw/rtl/fsmf_cell.sv
`timescale 1ns / 1ps

module fsmf_cell #(
  parameter int Position = 0
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  fsmf_pkg::cell_ctrl_t                         ctrl_i,
  input  logic [fsmf_pkg::ByteBits-1:0]                byte_i,
  input  logic [fsmf_pkg::PatRegBytes*fsmf_pkg::ByteBits-1:0] pattern_i,
  input  logic [fsmf_pkg::LenBits-1:0]                 len_i,
  output logic [fsmf_pkg::ByteBits-1:0]                byte_o,
  output logic                                         hit_o
);
  import fsmf_pkg::*;

  logic [ByteBits-1:0] win_q, win_d;
  logic [LenBits-1:0]  pat_idx;
  logic [3:0]          pat_sel;
  logic                in_use;

  // This cell compares against pattern byte (len - 1 - Position).
  assign in_use  = len_i > LenBits'(Position);
  assign pat_idx = len_i - LenBits'(Position) - LenBits'(1);
  assign pat_sel = pat_idx[3:0];

  // The compare looks at the byte that is shifted in during this beat.
  assign hit_o = !in_use || (byte_i == pattern_i[pat_sel*ByteBits +: ByteBits]);

  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.shift) begin
      win_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign byte_o = win_q;

endmodule

// File: hw/rtl/fsmf_checker.sv
`timescale 1ns / 1ps

module fsmf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // A not-found result always reports offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 32'd0)
    else $error("not-found result with nonzero offset");

  // A new result only follows an accepted text byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result beat without a text byte");

  // With the output register empty the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

endmodule

bind first_substring_match_finder_top fsmf_checker u_fsmf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fsmf_pkg::*;

  localparam int MaxPattern   = MaxPatternDef;
  localparam int PositionBits = PositionBitsDef;
  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 11;
  localparam int NumPhases    = 18;
  localparam int PhaseBytes   = 95;
  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 400;
  localparam int DrainLimit   = 20000;
  localparam int CycleLimit   = 300000;
  localparam int PrintLimit   = 50;

  typedef struct {
    logic [ByteBits-1:0] text_byte;
    logic                last_byte;
  } text_beat_t;

  typedef struct {
    logic                  found;
    logic [OffsetBits-1:0] offset;
  } search_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index     = '0;
  logic [PatWordBits-1:0] cfg_data     = '0;

  first_substring_match_finder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Text beats waiting to be driven, and search results still owed by the block.
  text_beat_t     text_q[$];
  search_result_t expected_results[$];

  int unsigned txt_idle_pct   = 13;
  int unsigned rx_idle_pct    = 59;
  int unsigned rx_hold_cycles = 0;
  bit          txt_fire       = 1'b0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned texts_sent     = 0;
  int unsigned hits_seen      = 0;
  int unsigned misses_seen    = 0;
  int unsigned reg_writes     = 0;

  // Mirror of the search engine: pattern registers, byte window and text progress.
  logic [PatWordBits-1:0]  pat_low_q        = '0;
  logic [PatWordBits-1:0]  pat_high_q       = '0;
  logic [LenBits-1:0]      pat_len_q        = LenBits'(1);
  logic [ByteBits-1:0]     window_q [MaxPattern];
  logic [PositionBits-1:0] position_q       = '0;
  bit                      match_reported_q = 1'b0;

  // Stimulus side: the pattern most recently programmed and the byte alphabet in use.
  logic [ByteBits-1:0] stim_pat [PatRegBytes];
  logic [ByteBits-1:0] text_buf[$];
  bit                  narrow_alphabet = 1'b0;
  logic [ByteBits-1:0] sym_a = '0;
  logic [ByteBits-1:0] sym_b = '0;

  initial begin
    foreach (window_q[i]) window_q[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // A length of zero acts as one; anything above the compare span is clipped to it.
  // The span is the window size or the sixteen pattern bytes, whichever is smaller.
  function automatic int unsigned used_length(input logic [LenBits-1:0] len_field);
    int unsigned cap;
    cap = (MaxPattern < PatRegBytes) ? MaxPattern : PatRegBytes;
    if (len_field == '0) return 1;
    if (32'(len_field) > cap) return cap;
    return 32'(len_field);
  endfunction

  function automatic logic [ByteBits-1:0] pattern_byte(input int unsigned k);
    if (k < 8) return pat_low_q[8*k +: 8];
    return pat_high_q[8*(k-8) +: 8];
  endfunction

  function automatic void predict_search(input logic [ByteBits-1:0] b, input logic last);
    int unsigned    len;
    bit             hit;
    search_result_t res;
    if (!match_reported_q) begin
      for (int i = MaxPattern - 1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = b;
      if (position_q != '1) position_q++;
      len = used_length(pat_len_q);
      hit = (position_q >= len);
      // The oldest byte of the candidate sits deepest in the window.
      for (int i = 0; i < len; i++) begin
        if (window_q[len-1-i] != pattern_byte(i)) hit = 1'b0;
      end
      if (hit) begin
        res.found  = 1'b1;
        res.offset = OffsetBits'(position_q - len);
        expected_results.push_back(res);
        match_reported_q = 1'b1;
      end else if (last) begin
        res.found  = 1'b0;
        res.offset = '0;
        expected_results.push_back(res);
      end
    end
    // The end of a text always rearms the search for the next one.
    if (last) begin
      foreach (window_q[i]) window_q[i] = '0;
      position_q       = '0;
      match_reported_q = 1'b0;
    end
  endfunction

  function automatic logic [ByteBits-1:0] pick_text_byte();
    if (!narrow_alphabet || $urandom_range(9) == 0) return ByteBits'($urandom);
    return $urandom_range(1) ? sym_a : sym_b;
  endfunction

  task automatic queue_text_buf();
    text_beat_t beat;
    foreach (text_buf[j]) begin
      beat.text_byte = text_buf[j];
      beat.last_byte = (j == text_buf.size() - 1);
      text_q.push_back(beat);
    end
    text_buf.delete();
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [PatWordBits-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every text beat went in and every owed result came out, then lets
  // the block settle, since bytes after a match leave no result to wait for.
  task automatic wait_idle();
    while (text_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Text driver: a beat is held until accepted, then replaced or withdrawn.
  always @(negedge clk_i) begin
    text_beat_t beat;
    if (rst_ni && (!s_axis_tvalid || txt_fire)) begin
      if (text_q.size() != 0 && $urandom_range(99) >= txt_idle_pct) begin
        beat = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat.text_byte;
        s_axis_tlast  <= beat.last_byte;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with an optional long hold-off counted down here.
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles = rx_hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: applies register writes to the mirror, checks result beats against the
  // oldest owed result and predicts the outcome of every accepted text byte.
  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles with %0d results owed", cycle_count,
                 expected_results.size());
        $display("Some tests failed");
        $finish;
      end else begin
        if (cfg_valid && cfg_ready) begin
          reg_writes++;
          case (cfg_index)
            CFG_PAT_LOW:  pat_low_q  = cfg_data;
            CFG_PAT_HIGH: pat_high_q = cfg_data;
            CFG_PAT_LEN:  pat_len_q  = cfg_data[LenBits-1:0];
            default: ;
          endcase
        end
        if (m_axis_tvalid && m_axis_tready) begin
          if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat: found %0d offset %0d",
                                      m_axis_tuser[0], m_axis_tdata));
          end else begin
            want = expected_results.pop_front();
            if (m_axis_tuser[0] !== want.found)
              report_mismatch($sformatf("found flag %b, expected %b", m_axis_tuser[0],
                                        want.found));
            if (m_axis_tdata !== want.offset)
              report_mismatch($sformatf("match offset %0d, expected %0d", m_axis_tdata,
                                        want.offset));
            if (want.found) hits_seen++;
            else misses_seen++;
          end
        end
        txt_fire = s_axis_tvalid && s_axis_tready;
        if (txt_fire) begin
          bytes_sent++;
          if (s_axis_tlast) texts_sent++;
          predict_search(s_axis_tdata, s_axis_tlast);
        end
      end
    end
  end

  initial begin
    text_beat_t           beat;
    int unsigned          kind;
    int unsigned          eff_len;
    int unsigned          phase_bytes;
    int unsigned          j;
    int unsigned          waited;
    logic [LenBits-1:0]   len_field;
    logic [PatWordBits-1:0] lo;
    logic [PatWordBits-1:0] hi;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset pattern is a single zero byte: it matches at once, and the bytes after the
    // match, the last one included, must stay silent.
    text_buf = '{8'h00, 8'hFF, 8'h12};
    queue_text_buf();
    // A one-byte text without a match reports not found.
    text_buf = '{8'hFF};
    queue_text_buf();
    wait_idle();

    // Full-length all-ones pattern, completed by the last byte of the text.
    write_reg(CFG_PAT_LOW, '1);
    write_reg(CFG_PAT_HIGH, '1);
    write_reg(CFG_PAT_LEN, PatWordBits'(MaxPattern));
    repeat (MaxPattern) text_buf.push_back(8'hFF);
    queue_text_buf();
    wait_idle();

    // Length zero acts as length one.
    write_reg(CFG_PAT_LEN, '0);
    text_buf = '{8'h01, 8'hFF};
    queue_text_buf();
    wait_idle();

    // Length change in the middle of a text keeps the bytes already in the window.
    beat.text_byte = 8'hAB;
    beat.last_byte = 1'b0;
    text_q.push_back(beat);
    wait_idle();
    write_reg(CFG_PAT_LOW, 64'h0000_0000_0000_CDAB);
    write_reg(CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE2);
    text_buf = '{8'hCD};
    queue_text_buf();
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph * 3 / NumPhases)
        0: begin
          txt_idle_pct = 13;
          rx_idle_pct  = 59;
        end
        1: begin
          txt_idle_pct = 59;
          rx_idle_pct  = 13;
        end
        default: begin
          txt_idle_pct = 0;
          rx_idle_pct  = 0;
        end
      endcase

      // A two-symbol alphabet makes near misses and overlapping candidates common.
      narrow_alphabet = $urandom_range(1);
      sym_a = ByteBits'($urandom);
      sym_b = ByteBits'($urandom);
      if (ph == 4) begin
        narrow_alphabet = 1'b1;
        sym_a = 8'hFF;
        sym_b = 8'hFF;
      end else if (ph == 10) begin
        narrow_alphabet = 1'b1;
        sym_a = 8'h00;
        sym_b = 8'h00;
      end
      foreach (stim_pat[k]) begin
        stim_pat[k] = narrow_alphabet ? ($urandom_range(1) ? sym_a : sym_b)
                                      : ByteBits'($urandom);
      end
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = stim_pat[k];
        hi[8*k +: 8] = stim_pat[k+8];
      end

      case (ph % 6)
        0: len_field = LenBits'(1);
        1: len_field = LenBits'(MaxPattern);
        2: len_field = '0;
        3: len_field = LenBits'($urandom_range(31, MaxPattern + 1));
        default: len_field = LenBits'($urandom_range(MaxPattern - 1, 2));
      endcase
      eff_len = used_length(len_field);

      write_reg(CFG_PAT_LOW, lo);
      write_reg(CFG_PAT_HIGH, hi);
      write_reg(CFG_PAT_LEN, {{(PatWordBits-32){1'b0}}, 32'($urandom)} << LenBits
                             | PatWordBits'(len_field));

      // Hold the result side off so that owed results pile up and the text input
      // backs up while the driver keeps offering bytes.
      if (ph == 13) begin
        @(posedge clk_i);
        rx_hold_cycles = HoldCycles;
      end

      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        kind = $urandom_range(9);
        if (kind <= 5) begin
          repeat ($urandom_range(12)) text_buf.push_back(pick_text_byte());
          for (int k = 0; k < eff_len; k++) text_buf.push_back(stim_pat[k]);
          if (kind == 5) begin
            // Spoil one byte of the planted pattern.
            j = text_buf.size() - 1 - $urandom_range(eff_len - 1);
            text_buf[j] = text_buf[j] ^ (8'h01 << $urandom_range(7));
          end
          repeat ($urandom_range(4)) text_buf.push_back(pick_text_byte());
        end else if (kind <= 7) begin
          repeat ($urandom_range(30, 1)) text_buf.push_back(pick_text_byte());
        end else if (kind == 8) begin
          repeat ($urandom_range(2, 1)) text_buf.push_back(pick_text_byte());
        end else begin
          // Two occurrences: only the first one may be reported.
          for (int k = 0; k < eff_len; k++) text_buf.push_back(stim_pat[k]);
          text_buf.push_back(pick_text_byte());
          for (int k = 0; k < eff_len; k++) text_buf.push_back(stim_pat[k]);
        end
        phase_bytes += text_buf.size();
        queue_text_buf();
      end
      wait_idle();
    end

    waited = 0;
    while ((text_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0) &&
           waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Searched %0d texts (%0d bytes): %0d matches and %0d misses checked.",
             texts_sent, bytes_sent, hits_seen, misses_seen);
    $display("Patterns of length 0, 1, 2 to 15, 16 and above 16 over %0d register writes.",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
